[design/base64_stream_encoder_core_assert.svh]
// Assertion macros shared by the base64 stream encoder RTL.
// Each macro expands to one labeled concurrent assertion with an
// active-low reset disable.
`ifndef BASE64_STREAM_ENCODER_CORE_ASSERT_SVH
`define BASE64_STREAM_ENCODER_CORE_ASSERT_SVH

// Same-cycle implication: whenever ante holds, cons must hold too.
`define B64E_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("b64e assertion failed: same-cycle implication");

// Next-cycle implication: whenever ante holds, cons must hold in the next cycle.
`define B64E_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("b64e assertion failed: next-cycle implication");

`endif

[design/b64e_pkg.sv]
`timescale 1ns / 1ps
// Package for the base64 stream encoder: job record, phase type, character
// constants and the 6-bit code to ASCII mapping. No dependencies.
package b64e_pkg;

    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int NUM_SYM         = 4;

    localparam logic [6:0] PAD_CHAR     = 7'h3D;  // '='
    localparam logic [6:0] PLUS_CHAR    = 7'h2B;  // '+'
    localparam logic [6:0] SLASH_CHAR   = 7'h2F;  // '/'
    localparam logic [6:0] UPPER_A_CHAR = 7'h41;  // 'A'
    localparam logic [6:0] LOWER_A_CHAR = 7'h61;  // 'a'
    localparam logic [6:0] DIGIT_0_CHAR = 7'h30;  // '0'

    // Byte position within the current 3-byte group.
    typedef enum logic [2:0] {
        PH_FIRST  = 3'b001,
        PH_SECOND = 3'b010,
        PH_THIRD  = 3'b100
    } t_phase;

    // One classified input byte: up to four 6-bit symbols, which of them are
    // pad characters, the index of the final one and the end-of-message flag.
    typedef struct packed {
        logic [1:0]             n_last;
        logic [NUM_SYM-1:0][5:0] sym;
        logic [NUM_SYM-1:0]     pad;
        logic                   last;
    } t_job;

    function automatic logic [6:0] code_char(input logic [5:0] v);
        logic [6:0] w;
        w = {1'b0, v};
        if (v < 6'd26) begin
            return UPPER_A_CHAR + w;
        end else if (v < 6'd52) begin
            return LOWER_A_CHAR + w - 7'd26;
        end else if (v < 6'd62) begin
            return DIGIT_0_CHAR + w - 7'd52;
        end else if (v == 6'd62) begin
            return PLUS_CHAR;
        end else begin
            return SLASH_CHAR;
        end
    endfunction

endpackage

[design/b64e_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the base64 stream encoder:
// the byte input channel and the character output channel. No dependencies.
interface b64e_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       is_last;

    modport source (output valid, output data_byte, output is_last, input ready);
    modport sink   (input valid, input data_byte, input is_last, output ready);
endinterface

interface b64e_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] out_char;
    logic       run_last;
    logic       message_end;

    modport source (output valid, output out_char, output run_last, output message_end,
                    input ready);
    modport sink   (input valid, input out_char, input run_last, input message_end,
                    output ready);
endinterface

[design/b64e_front.sv]
`timescale 1ns / 1ps
// Front end of the base64 stream encoder: accepts bytes, tracks the group
// phase and leftover bits, and turns each byte into a job. Uses b64e_pkg.
module b64e_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    b64e_in_if.sink        i_in,
    input  logic           i_q_full,
    output logic           o_push,
    output b64e_pkg::t_job o_job,
    output b64e_pkg::t_phase o_phase
);
    import b64e_pkg::*;

    t_phase     r_phase, n_phase;
    logic [3:0] r_left,  n_left;
    logic [7:0] w_byte;

    assign w_byte     = i_in.data_byte;
    assign i_in.ready = !i_q_full;
    assign o_push     = i_in.valid && !i_q_full;
    assign o_phase    = r_phase;

    always_comb begin
        o_job      = '0;
        o_job.last = i_in.is_last;
        n_phase    = r_phase;
        n_left     = r_left;
        unique case (r_phase)
            PH_SECOND: begin
                o_job.sym[0] = {r_left[1:0], w_byte[7:4]};
                if (i_in.is_last) begin
                    o_job.sym[1] = {w_byte[3:0], 2'b00};
                    o_job.pad[2] = 1'b1;
                    o_job.n_last = 2'd2;
                end
                n_phase = PH_THIRD;
                n_left  = w_byte[3:0];
            end
            PH_THIRD: begin
                o_job.sym[0] = {r_left, w_byte[7:6]};
                o_job.sym[1] = w_byte[5:0];
                o_job.n_last = 2'd1;
                n_phase      = PH_FIRST;
                n_left       = '0;
            end
            default: begin
                o_job.sym[0] = w_byte[7:2];
                if (i_in.is_last) begin
                    o_job.sym[1] = {w_byte[1:0], 4'b0000};
                    o_job.pad[2] = 1'b1;
                    o_job.pad[3] = 1'b1;
                    o_job.n_last = 2'd3;
                end
                n_phase = PH_SECOND;
                n_left  = {2'b00, w_byte[1:0]};
            end
        endcase
        // A final byte closes the message and starts a fresh group.
        if (i_in.is_last) begin
            n_phase = PH_FIRST;
            n_left  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FIRST;
            r_left  <= '0;
        end else if (o_push) begin
            r_phase <= n_phase;
            r_left  <= n_left;
        end
    end

endmodule

[design/b64e_queue.sv]
`timescale 1ns / 1ps
// Small job queue between the front and back ends of the base64 encoder.
// Circular buffer of t_job entries. Uses b64e_pkg.
module b64e_queue #(
    parameter int DEPTH = b64e_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  b64e_pkg::t_job             i_job,
    input  logic                       i_pop,
    output b64e_pkg::t_job             o_job,
    output logic                       o_full,
    output logic                       o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);
    import b64e_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_job          r_slot [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;
    logic          w_wr, w_rd;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_job   = r_slot[r_rd];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_slot[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_wr) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
            end
            if (w_rd) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[design/b64e_back.sv]
`timescale 1ns / 1ps
// Back end of the base64 encoder: takes jobs from the queue and sends their
// characters one per transfer through a registered output. Uses b64e_pkg.
module b64e_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  b64e_pkg::t_job i_job,
    output logic           o_pop,
    b64e_out_if.source     o_out
);
    import b64e_pkg::*;

    t_job       r_job;
    logic       r_have;
    logic [1:0] r_idx;
    logic       r_out_valid;
    logic [6:0] r_out_char;
    logic       r_out_run_last;
    logic       r_out_msg_end;
    logic       w_slot, w_fire, w_done;
    logic [6:0] w_char;

    assign w_slot = !r_out_valid || o_out.ready;
    assign w_fire = r_have && w_slot;
    assign w_done = w_fire && (r_idx == r_job.n_last);
    // The next job is taken in the same cycle the current one sends its
    // final character, so characters flow without a gap.
    assign o_pop  = !i_empty && (!r_have || w_done);
    assign w_char = r_job.pad[r_idx] ? PAD_CHAR : code_char(r_job.sym[r_idx]);

    assign o_out.valid       = r_out_valid;
    assign o_out.out_char    = r_out_char;
    assign o_out.run_last    = r_out_run_last;
    assign o_out.message_end = r_out_msg_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_have <= 1'b1;
                r_idx  <= '0;
            end else if (w_done) begin
                r_have <= 1'b0;
            end else if (w_fire) begin
                r_idx <= r_idx + 1'b1;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (w_fire) begin
            r_out_char     <= w_char;
            r_out_run_last <= w_done;
            r_out_msg_end  <= w_done && r_job.last;
        end
    end

endmodule

[design/base64_stream_encoder_core.sv]
`timescale 1ns / 1ps
// Top level of the base64 stream encoder: front end, job queue, back end.
// Uses b64e_pkg, b64e_if and base64_stream_encoder_core_assert.svh.
//
// Usage: bytes enter on i_in (data_byte, is_last); characters leave on o_out
// (out_char, run_last, message_end), both valid/ready channels where a
// transfer happens when valid and ready are high at a rising clock edge.
// Each byte yields one or two base64 characters; a byte with is_last set
// also flushes the partial group and appends '=' padding, so one byte gives
// one to four characters. run_last marks the last character of a byte and
// message_end the last character of a message.
// A byte's job is written to a queue slot and loaded into the back end's job
// register; each character then passes through the output register. The back
// end sends one character per cycle while the receiver is ready, so the block
// takes one byte per cycle while the queue has room; the one-character output
// channel limits a continuous stream to about three bytes per four characters.
// Reset clears the group phase, the queue and the output valid flag.
// When the receiver stalls, the output holds its character, the queue fills
// and i_in.ready drops once QUEUE_DEPTH jobs wait.
`include "base64_stream_encoder_core_assert.svh"
module base64_stream_encoder_core #(
    parameter int QUEUE_DEPTH = b64e_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    b64e_in_if.sink    i_in,
    b64e_out_if.source o_out
);
    import b64e_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

    t_job          w_push_job, w_head_job;
    t_phase        w_phase;
    logic          w_push, w_pop, w_full, w_empty;
    logic [CW-1:0] w_count;
    logic          w_end_char, w_last_xfer;

    b64e_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (w_full),
        .o_push   (w_push),
        .o_job    (w_push_job),
        .o_phase  (w_phase)
    );

    b64e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_job   (w_head_job),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_count (w_count)
    );

    b64e_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_job   (w_head_job),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

    assign w_end_char  = o_out.valid && o_out.message_end;
    assign w_last_xfer = i_in.valid && i_in.ready && i_in.is_last;

    // The last character of a message is always the last one of its byte.
    `B64E_ASSERT_IMPLY(a_end_is_run_last, i_clk, i_rst_n, w_end_char, o_out.run_last)
    // A full queue must hold off the input so no job is lost.
    `B64E_ASSERT_IMPLY(a_full_blocks_input, i_clk, i_rst_n, w_count == FULL_CNT, !i_in.ready)
    // A final byte returns the encoder to the start of a group.
    `B64E_ASSERT_NEXT(a_last_restarts_group, i_clk, i_rst_n, w_last_xfer, w_phase == PH_FIRST)

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for base64_stream_encoder_core: a directed table of bytes and
// random messages under four pacing profiles, checked against an in-bench encoder model.
// Depends on b64e_pkg, b64e_if and the RTL of the encoder core.
module testbench;
    import b64e_pkg::*;

    typedef struct packed {
        logic [6:0] ch;
        logic       byte_end;
        logic       msg_end;
    } t_enc_char;

    typedef struct {
        logic [7:0] data;
        logic       last;
        string      typed;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    b64e_in_if  in_ch ();
    b64e_out_if out_ch ();

    base64_stream_encoder_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Encoder model state: position in the 3-byte group and the bits still owed.
    logic [1:0] grp_phase  = 2'd0;
    logic [3:0] carry_bits = 4'd0;

    t_enc_char pending_chars[$];
    t_stim_row directed_rows[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int bytes_sent     = 0;
    int messages_sent  = 0;
    int chars_checked  = 0;
    int errors         = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic logic [6:0] sextet_char(input logic [5:0] v);
        if (v <= 6'd25) begin
            return UPPER_A_CHAR + 7'(v);
        end else if (v <= 6'd51) begin
            return LOWER_A_CHAR + 7'(v - 6'd26);
        end else if (v <= 6'd61) begin
            return DIGIT_0_CHAR + 7'(v - 6'd52);
        end
        return v[0] ? SLASH_CHAR : PLUS_CHAR;
    endfunction

    // Advances the model by one byte and returns the number of characters it yields.
    function automatic int encode_byte(input logic [7:0] b, input logic last,
                                       output logic [3:0][6:0] chars);
        int n;
        chars = '0;
        case (grp_phase)
            2'd1: begin
                chars[0] = sextet_char({carry_bits[1:0], b[7:4]});
                n = 1;
                if (last) begin
                    chars[1] = sextet_char({b[3:0], 2'b00});
                    chars[2] = PAD_CHAR;
                    n = 3;
                end
                grp_phase  = 2'd2;
                carry_bits = b[3:0];
            end
            2'd2: begin
                chars[0] = sextet_char({carry_bits, b[7:6]});
                chars[1] = sextet_char(b[5:0]);
                n = 2;
                grp_phase  = 2'd0;
                carry_bits = 4'd0;
            end
            default: begin
                chars[0] = sextet_char(b[7:2]);
                n = 1;
                if (last) begin
                    chars[1] = sextet_char({b[1:0], 4'b0000});
                    chars[2] = PAD_CHAR;
                    chars[3] = PAD_CHAR;
                    n = 4;
                end
                grp_phase  = 2'd1;
                carry_bits = {2'b00, b[1:0]};
            end
        endcase
        if (last) begin
            grp_phase  = 2'd0;
            carry_bits = 4'd0;
        end
        return n;
    endfunction

    function automatic void add_row(input logic [7:0] data, input logic last, input string typed);
        t_stim_row r;
        r.data  = data;
        r.last  = last;
        r.typed = typed;
        directed_rows.push_back(r);
    endfunction

    // Presents one byte, waits for its transfer and queues the characters it should yield.
    // A non-empty typed string replaces the model's characters for that byte.
    task automatic send_byte(input logic [7:0] b, input logic last, input string typed);
        logic [3:0][6:0] chars;
        int              n;
        byte             c;
        t_enc_char       e;
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.is_last   <= last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        n = encode_byte(b, last, chars);
        if (typed.len() != 0) begin
            n = typed.len();
            for (int k = 0; k < n; k++) begin
                c = typed[k];
                chars[k] = c[6:0];
            end
        end
        for (int k = 0; k < n; k++) begin
            e.ch       = chars[k];
            e.byte_end = (k == n - 1);
            e.msg_end  = (k == n - 1) && last;
            pending_chars.push_back(e);
        end
        bytes_sent++;
        if (last) messages_sent++;
        @(negedge i_clk);
    endtask

    // Random messages, mostly short so that every group position ends a message often.
    task automatic send_messages(input int idle_pct, input int stall_pct, input int count);
        int         sent;
        int         len;
        logic [7:0] b;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < count) begin
            len = ($urandom_range(9) < 7) ? $urandom_range(1, 6) : $urandom_range(7, 20);
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(7) == 0) begin
                    b = $urandom_range(1) ? 8'hFF : 8'h00;
                end else begin
                    b = 8'($urandom);
                end
                send_byte(b, k == len - 1, "");
            end
            sent += len;
        end
    endtask

    always @(negedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_enc_char want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_chars.size() == 0) begin
                $error("unexpected character transfer: out_char %h", out_ch.out_char);
                errors++;
            end else begin
                want = pending_chars.pop_front();
                chars_checked++;
                if (out_ch.out_char !== want.ch) begin
                    $error("out_char mismatch: expected %h, actual %h", want.ch, out_ch.out_char);
                    errors++;
                end
                if (out_ch.run_last !== want.byte_end) begin
                    $error("run_last mismatch: expected %b, actual %b",
                           want.byte_end, out_ch.run_last);
                    errors++;
                end
                if (out_ch.message_end !== want.msg_end) begin
                    $error("message_end mismatch: expected %b, actual %b",
                           want.msg_end, out_ch.message_end);
                    errors++;
                end
            end
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.data_byte = 8'h00;
        in_ch.is_last   = 1'b0;
        out_ch.ready    = 1'b0;

        // Single-byte messages at both extremes.
        add_row(8'h00, 1'b1, "AA==");
        add_row(8'hFF, 1'b1, "/w==");
        // "Man" ends on the third byte of a group, so no padding follows.
        add_row(8'h4D, 1'b0, "T");
        add_row(8'h61, 1'b0, "W");
        add_row(8'h6E, 1'b1, "Fu");
        // "Ma" ends on the second byte and takes one pad character.
        add_row(8'h4D, 1'b0, "T");
        add_row(8'h61, 1'b1, "WE=");
        // Zero bytes are ordinary data.
        add_row(8'h00, 1'b0, "A");
        add_row(8'h00, 1'b0, "A");
        add_row(8'h00, 1'b1, "AA");
        add_row(8'hFF, 1'b0, "");
        add_row(8'hFF, 1'b0, "");
        add_row(8'hFF, 1'b1, "");
        add_row(8'hF8, 1'b1, "");
        add_row(8'h55, 1'b0, "");
        add_row(8'hAA, 1'b0, "");
        add_row(8'h7F, 1'b1, "");
        add_row(8'h80, 1'b0, "");
        add_row(8'h01, 1'b1, "");
        add_row(8'hD3, 1'b0, "");
        add_row(8'h5D, 1'b0, "");
        add_row(8'hB7, 1'b1, "");
        add_row(8'h3E, 1'b0, "");
        add_row(8'hFC, 1'b1, "");

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            send_byte(directed_rows[i].data, directed_rows[i].last, directed_rows[i].typed);
        end

        send_messages(0, 0, 42);
        send_messages(85, 0, 42);
        send_messages(0, 85, 42);
        send_messages(26, 26, 42);

        in_ch.valid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Encoded %0d bytes in %0d messages and checked %0d characters,",
                 bytes_sent, messages_sent, chars_checked);
        $display("with free-running, sender-idle, receiver-stall and mixed pacing.");
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
